[sv/kmc_pkg.sv]
// shared widths and types for the two-dimensional k-means engine
package kmc_pkg;

   localparam int COORD_W = 16;
   localparam int PIDX_W  = 6;
   localparam int CIDX_W  = 3;
   localparam int ITER_W  = 8;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [ITER_W-1:0]  iter_type;

endpackage

[sv/kmc_if.sv]
// request, response and register-write channel interfaces of the k-means engine
interface kmc_req_if
   import kmc_pkg::*;
   ();
   logic      valid;
   logic      ready;
   logic      req_type;
   coord_type coord_x;
   coord_type coord_y;
   logic      last_item;

   modport source (output valid, req_type, coord_x, coord_y, last_item, input ready);
   modport sink   (input valid, req_type, coord_x, coord_y, last_item, output ready);
endinterface

interface kmc_rsp_if
   import kmc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [PIDX_W-1:0] point_index;
   logic [CIDX_W-1:0] cluster_index;
   logic              hit_limit;
   logic              last_result;

   modport source (output valid, point_index, cluster_index, hit_limit, last_result,
                   input ready);
   modport sink   (input valid, point_index, cluster_index, hit_limit, last_result,
                   output ready);
endinterface

interface kmc_csr_if
   import kmc_pkg::*;
   ();
   logic     valid;
   logic     ready;
   iter_type data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[sv/kmc_div.sv]
// restoring unsigned divider, one quotient bit per cycle
module kmc_div #(
   parameter int NW = 22,
   parameter int DW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   assign trial = {rem_ff, num_ff[NW-1]};

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

[sv/kmeans_2d_cluster_engine.sv]
// two-dimensional k-means engine: load stores, assign/update passes, per-point results
//
//  channel | dir | handshake     | carries
//  req     | in  | valid/ready   | req_type, coord_x, coord_y, last_item
//  rsp     | out | valid/ready   | point_index, cluster_index, hit_limit, last_result
//  csr     | in  | valid/ready   | data = max_iterations
//
// loading takes one request per cycle; a request with last_item starts the run
// one pass: each point is labelled with its nearest center and summed into that
// center's accumulator; each center with members then takes the truncated mean
// from NW-bit serial dividers, NW = 16 + clog2(MAX_POINTS+1); a final assign follows
// results go out one at a time; rsp stalls hold the engine, req waits meanwhile
// reset (synchronous) clears control and the run start sweeps the accumulators
module kmeans_2d_cluster_engine
   import kmc_pkg::*;
#(
   parameter int MAX_POINTS   = 64,
   parameter int MAX_CLUSTERS = 8
) (
   input  logic clock,
   input  logic reset,
   kmc_req_if.sink   req,
   kmc_rsp_if.source rsp,
   kmc_csr_if.sink   csr
);

   localparam int PIW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int PCW  = $clog2(MAX_POINTS + 1);
   localparam int CIW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int CCW  = $clog2(MAX_CLUSTERS + 1);
   localparam int SUMW = COORD_W + PCW;
   localparam int ACCW = PCW + 2 * SUMW;
   localparam int PTW  = 2 * COORD_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_CLR   = 4'd2;
   localparam logic [3:0] S_ARD   = 4'd3;
   localparam logic [3:0] S_ADIF  = 4'd4;
   localparam logic [3:0] S_ASQ   = 4'd5;
   localparam logic [3:0] S_ACMP  = 4'd6;
   localparam logic [3:0] S_AWR   = 4'd7;
   localparam logic [3:0] S_AACC  = 4'd8;
   localparam logic [3:0] S_URD   = 4'd9;
   localparam logic [3:0] S_UDIV  = 4'd10;
   localparam logic [3:0] S_UWAIT = 4'd11;
   localparam logic [3:0] S_UWB   = 4'd12;
   localparam logic [3:0] S_ERD   = 4'd13;
   localparam logic [3:0] S_EOUT  = 4'd14;

   // memories
   logic [PTW-1:0]  pt_mem  [MAX_POINTS];
   logic [CIW-1:0]  lab_mem [MAX_POINTS];
   logic [PTW-1:0]  cen_mem [MAX_CLUSTERS];
   logic [ACCW-1:0] acc_mem [MAX_CLUSTERS];
   logic [PTW-1:0]  pt_q_ff, cen_q_ff;
   logic [CIW-1:0]  lab_q_ff;
   logic [ACCW-1:0] acc_q_ff;

   logic            pt_we,  cen_we,  lab_we,  acc_we;
   logic            pt_re,  cen_re,  lab_re,  acc_re;
   logic [PIW-1:0]  pt_wa,  pt_ra,  lab_a;
   logic [CIW-1:0]  cen_wa, cen_ra, acc_wa, acc_ra;
   logic [PTW-1:0]  pt_wd,  cen_wd;
   logic [CIW-1:0]  lab_wd;
   logic [ACCW-1:0] acc_wd;

   // control
   logic [3:0]     state_ff, state_in;
   logic [PCW-1:0] pcnt_ff, pcnt_in, i_ff, i_in;
   logic [CCW-1:0] ccnt_ff, ccnt_in, c_ff, c_in;
   logic [CIW-1:0] best_ff, best_in;
   logic [PTW:0]   bestd_ff, bestd_in;
   coord_type      dx_ff, dx_in, dy_ff, dy_in;
   logic [PTW-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   iter_type       pass_ff, pass_in, maxit_ff;
   logic           moved_ff, moved_in, hit_ff, hit_in;
   logic           final_ff, final_in, nocen_ff, nocen_in;

   logic           req_acc, rsp_acc;
   coord_type      px, py, cx, cy, qx, qy;
   logic [PTW:0]   sq_sum;
   logic [8:0]     cap;
   logic           moved_now;
   logic           div_start, divx_done, divy_done;
   logic [SUMW-1:0] quox, quoy;
   logic [PCW-1:0] acc_cnt;
   logic [SUMW-1:0] acc_sx, acc_sy;

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign req_acc   = req.valid & req.ready;
   assign rsp_acc   = rsp.valid & rsp.ready;

   assign px      = pt_q_ff[PTW-1:COORD_W];
   assign py      = pt_q_ff[COORD_W-1:0];
   assign cx      = cen_q_ff[PTW-1:COORD_W];
   assign cy      = cen_q_ff[COORD_W-1:0];
   assign acc_cnt = acc_q_ff[ACCW-1:2*SUMW];
   assign acc_sy  = acc_q_ff[2*SUMW-1:SUMW];
   assign acc_sx  = acc_q_ff[SUMW-1:0];
   assign qx      = quox[COORD_W-1:0];
   assign qy      = quoy[COORD_W-1:0];
   assign sq_sum  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign cap     = (maxit_ff == '0) ? 9'd1 : {1'b0, maxit_ff};
   assign moved_now = moved_ff | ((acc_cnt != '0) && ((qx != cx) || (qy != cy)));
   assign div_start = (state_ff == S_UDIV) && (acc_cnt != '0);

   kmc_div #(.NW(SUMW), .DW(PCW)) u_divx (
      .clock(clock), .reset(reset), .start(div_start),
      .num(acc_sx), .den(acc_cnt), .done(divx_done), .quo(quox)
   );

   kmc_div #(.NW(SUMW), .DW(PCW)) u_divy (
      .clock(clock), .reset(reset), .start(div_start),
      .num(acc_sy), .den(acc_cnt), .done(divy_done), .quo(quoy)
   );

   always_comb begin
      state_in = state_ff;
      pcnt_in  = pcnt_ff;
      ccnt_in  = ccnt_ff;
      i_in     = i_ff;
      c_in     = c_ff;
      best_in  = best_ff;
      bestd_in = bestd_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      sqx_in   = sqx_ff;
      sqy_in   = sqy_ff;
      pass_in  = pass_ff;
      moved_in = moved_ff;
      hit_in   = hit_ff;
      final_in = final_ff;
      nocen_in = nocen_ff;

      pt_we  = 1'b0;
      pt_wa  = pcnt_ff[PIW-1:0];
      pt_wd  = {req.coord_x, req.coord_y};
      pt_re  = 1'b0;
      pt_ra  = i_ff[PIW-1:0];
      cen_we = 1'b0;
      cen_wa = ccnt_ff[CIW-1:0];
      cen_wd = {req.coord_x, req.coord_y};
      cen_re = 1'b0;
      cen_ra = c_ff[CIW-1:0];
      lab_we = 1'b0;
      lab_re = 1'b0;
      lab_a  = i_ff[PIW-1:0];
      lab_wd = best_ff;
      acc_we = 1'b0;
      acc_wa = c_ff[CIW-1:0];
      acc_wd = '0;
      acc_re = 1'b0;
      acc_ra = best_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (!req.req_type) begin
                  if (pcnt_ff < PCW'(MAX_POINTS)) begin
                     pt_we   = 1'b1;
                     pcnt_in = pcnt_ff + 1'b1;
                  end
               end else begin
                  if (ccnt_ff < CCW'(MAX_CLUSTERS)) begin
                     cen_we  = 1'b1;
                     ccnt_in = ccnt_ff + 1'b1;
                  end
               end
               if (req.last_item) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            pass_in  = '0;
            hit_in   = 1'b0;
            final_in = 1'b0;
            moved_in = 1'b0;
            nocen_in = (ccnt_ff == '0);
            i_in     = '0;
            c_in     = '0;
            if (pcnt_ff == '0) begin
               ccnt_in  = '0;
               state_in = S_IDLE;
            end else if (ccnt_ff == '0) begin
               state_in = S_ERD;
            end else begin
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            acc_we = 1'b1;
            c_in   = c_ff + 1'b1;
            if (c_ff == ccnt_ff - 1'b1) begin
               i_in     = '0;
               state_in = S_ARD;
            end
         end
         S_ARD: begin
            pt_re    = 1'b1;
            cen_re   = 1'b1;
            cen_ra   = '0;
            c_in     = '0;
            state_in = S_ADIF;
         end
         S_ADIF: begin
            dx_in    = (px >= cx) ? px - cx : cx - px;
            dy_in    = (py >= cy) ? py - cy : cy - py;
            state_in = S_ASQ;
         end
         S_ASQ: begin
            sqx_in   = dx_ff * dx_ff;
            sqy_in   = dy_ff * dy_ff;
            state_in = S_ACMP;
         end
         S_ACMP: begin
            // strict compare keeps the lower index on a tie
            if ((c_ff == '0) || (sq_sum < bestd_ff)) begin
               bestd_in = sq_sum;
               best_in  = c_ff[CIW-1:0];
            end
            if (c_ff == ccnt_ff - 1'b1) begin
               state_in = S_AWR;
            end else begin
               c_in     = c_ff + 1'b1;
               cen_re   = 1'b1;
               cen_ra   = CIW'(c_ff + 1'b1);
               state_in = S_ADIF;
            end
         end
         S_AWR: begin
            lab_we = 1'b1;
            if (final_ff) begin
               if (i_ff == pcnt_ff - 1'b1) begin
                  i_in     = '0;
                  state_in = S_ERD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_ARD;
               end
            end else begin
               acc_re   = 1'b1;
               state_in = S_AACC;
            end
         end
         S_AACC: begin
            acc_we = 1'b1;
            acc_wa = best_ff;
            acc_wd = {acc_cnt + 1'b1,
                      acc_sy + SUMW'(py),
                      acc_sx + SUMW'(px)};
            if (i_ff == pcnt_ff - 1'b1) begin
               c_in     = '0;
               moved_in = 1'b0;
               state_in = S_URD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_ARD;
            end
         end
         S_URD: begin
            acc_re   = 1'b1;
            acc_ra   = c_ff[CIW-1:0];
            cen_re   = 1'b1;
            state_in = S_UDIV;
         end
         S_UDIV: begin
            state_in = (acc_cnt != '0) ? S_UWAIT : S_UWB;
         end
         S_UWAIT: begin
            if (divx_done & divy_done) begin
               state_in = S_UWB;
            end
         end
         S_UWB: begin
            // accumulator entry is cleared here for the next pass
            acc_we   = 1'b1;
            moved_in = moved_now;
            if (acc_cnt != '0) begin
               cen_we = 1'b1;
               cen_wa = c_ff[CIW-1:0];
               cen_wd = {qx, qy};
            end
            if (c_ff == ccnt_ff - 1'b1) begin
               pass_in = pass_ff + 1'b1;
               i_in    = '0;
               if (!(moved_now && ({1'b0, pass_ff} + 9'd1 < cap))) begin
                  hit_in   = moved_now;
                  final_in = 1'b1;
               end
               state_in = S_ARD;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = S_URD;
            end
         end
         S_ERD: begin
            lab_re   = 1'b1;
            state_in = S_EOUT;
         end
         S_EOUT: begin
            if (rsp_acc) begin
               if (i_ff == pcnt_ff - 1'b1) begin
                  pcnt_in  = '0;
                  ccnt_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pcnt_ff  <= '0;
         ccnt_ff  <= '0;
         i_ff     <= '0;
         c_ff     <= '0;
         pass_ff  <= '0;
         moved_ff <= 1'b0;
         hit_ff   <= 1'b0;
         final_ff <= 1'b0;
         nocen_ff <= 1'b0;
         maxit_ff <= iter_type'(32);
      end else begin
         state_ff <= state_in;
         pcnt_ff  <= pcnt_in;
         ccnt_ff  <= ccnt_in;
         i_ff     <= i_in;
         c_ff     <= c_in;
         pass_ff  <= pass_in;
         moved_ff <= moved_in;
         hit_ff   <= hit_in;
         final_ff <= final_in;
         nocen_ff <= nocen_in;
         if (csr.valid & csr.ready) begin
            maxit_ff <= csr.data;
         end
      end
      best_ff  <= best_in;
      bestd_ff <= bestd_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_wa] <= pt_wd;
      end
      if (pt_re) begin
         pt_q_ff <= pt_mem[pt_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cen_we) begin
         cen_mem[cen_wa] <= cen_wd;
      end
      if (cen_re) begin
         cen_q_ff <= cen_mem[cen_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (lab_we) begin
         lab_mem[lab_a] <= lab_wd;
      end
      if (lab_re) begin
         lab_q_ff <= lab_mem[lab_a];
      end
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wa] <= acc_wd;
      end
      if (acc_re) begin
         acc_q_ff <= acc_mem[acc_ra];
      end
   end

   assign rsp.valid         = (state_ff == S_EOUT);
   assign rsp.point_index   = PIDX_W'(i_ff);
   assign rsp.cluster_index = nocen_ff ? '0 : CIDX_W'(lab_q_ff);
   assign rsp.hit_limit     = hit_ff;
   assign rsp.last_result   = (i_ff == pcnt_ff - 1'b1);

endmodule

[test/kmc_tb_if.sv]
// helper types for the k-means engine testbench
package kmc_tb_pkg;
   import kmc_pkg::*;

   typedef enum logic {LOAD_POINT = 1'b0, LOAD_CENTER = 1'b1} load_kind_type;

   typedef struct {
      load_kind_type kind;
      coord_type     x;
      coord_type     y;
      logic          last;
   } load_request_type;

   typedef struct {
      logic [PIDX_W-1:0] point;
      logic [CIDX_W-1:0] cluster;
      logic              hit;
      logic              last;
   } label_result_type;
endpackage

[test/testbench.sv]
// testbench for the k-means engine: load requests, predicted labels, response check
module testbench;
   import kmc_pkg::*;
   import kmc_tb_pkg::*;

   localparam int NPTS = 64;
   localparam int NCTR = 8;
   localparam int WATCHDOG_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kmc_req_if req ();
   kmc_rsp_if rsp ();
   kmc_csr_if csr ();

   kmeans_2d_cluster_engine dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state
   logic [15:0] px [NPTS];
   logic [15:0] py [NPTS];
   logic [2:0]  plabel [NPTS];
   logic [15:0] cx [NCTR];
   logic [15:0] cy [NCTR];
   int          n_points;
   int          n_centers;
   logic [7:0]  pass_cap;

   load_request_type pending_loads [$];
   label_result_type expected_labels [$];
   load_request_type batch [$];

   int  mismatches = 0;
   bit  failed = 0;
   int  idle_cycles = 0;
   bit  loading_done = 0;

   function automatic logic [32:0] dist2(logic [15:0] ax, logic [15:0] ay,
                                        logic [15:0] bx, logic [15:0] by);
      logic [15:0] dx;
      logic [15:0] dy;
      dx = (ax >= bx) ? ax - bx : bx - ax;
      dy = (ay >= by) ? ay - by : by - ay;
      return {1'b0, 32'(dx) * 32'(dx)} + {1'b0, 32'(dy) * 32'(dy)};
   endfunction

   function automatic void label_points();
      logic [32:0] best_d;
      logic [32:0] d;
      for (int i = 0; i < n_points; i++) begin
         plabel[i] = '0;
         best_d = '0;
         for (int c = 0; c < n_centers; c++) begin
            d = dist2(px[i], py[i], cx[c], cy[c]);
            if (c == 0 || d < best_d) begin
               plabel[i] = 3'(c);
               best_d = d;
            end
         end
      end
   endfunction

   function automatic bit move_centers();
      logic [31:0] sx [NCTR];
      logic [31:0] sy [NCTR];
      int          cnt [NCTR];
      logic [15:0] nx;
      logic [15:0] ny;
      bit          moved;
      moved = 0;
      for (int c = 0; c < NCTR; c++) begin
         sx[c] = 0; sy[c] = 0; cnt[c] = 0;
      end
      for (int i = 0; i < n_points; i++) begin
         sx[plabel[i]] += px[i];
         sy[plabel[i]] += py[i];
         cnt[plabel[i]]++;
      end
      for (int c = 0; c < n_centers; c++) begin
         if (cnt[c] != 0) begin
            nx = 16'(sx[c] / cnt[c]);
            ny = 16'(sy[c] / cnt[c]);
            if (nx != cx[c] || ny != cy[c]) moved = 1;
            cx[c] = nx;
            cy[c] = ny;
         end
      end
      return moved;
   endfunction

   // store one request; on last, run the clustering and queue the labels
   function automatic void predict_labels(load_request_type r);
      int  cap;
      int  passes;
      bit  moved;
      bit  hit;
      label_result_type res;
      hit = 0;
      if (r.kind == LOAD_POINT) begin
         if (n_points < NPTS) begin
            px[n_points] = r.x; py[n_points] = r.y; n_points++;
         end
      end else if (n_centers < NCTR) begin
         cx[n_centers] = r.x; cy[n_centers] = r.y; n_centers++;
      end
      if (!r.last) return;
      cap = (pass_cap == 0) ? 1 : int'(pass_cap);
      if (n_centers == 0) begin
         for (int i = 0; i < n_points; i++) plabel[i] = '0;
      end else begin
         moved = 1;
         passes = 0;
         while (moved && passes < cap) begin
            label_points();
            moved = move_centers();
            passes++;
         end
         hit = moved;
         label_points();
      end
      for (int i = 0; i < n_points; i++) begin
         res.point = PIDX_W'(i);
         res.cluster = plabel[i];
         res.hit = hit;
         res.last = (i + 1 == n_points);
         expected_labels.push_back(res);
      end
      n_points = 0;
      n_centers = 0;
   endfunction

   // random gap: none half the time, else mostly short, sometimes long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset || !loading_done) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            predict_labels(pending_loads.pop_front());
            req_gap = pick_gap();
         end
         if (pending_loads.size() != 0 && req_gap == 0 && !csr.valid) begin
            req.valid     <= 1'b1;
            req.req_type  <= pending_loads[0].kind;
            req.coord_x   <= pending_loads[0].x;
            req.coord_y   <= pending_loads[0].y;
            req.last_item <= pending_loads[0].last;
         end else begin
            req.valid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   label_result_type got;
   label_result_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.point = rsp.point_index;
            got.cluster = rsp.cluster_index;
            got.hit = rsp.hit_limit;
            got.last = rsp.last_result;
            if (expected_labels.size() == 0) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: point %0d cluster %0d", got.point,
                           got.cluster);
            end else begin
               want = expected_labels.pop_front();
               if (got.point != want.point || got.cluster != want.cluster ||
                   got.hit != want.hit || got.last != want.last) begin
                  failed = 1;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("label mismatch: exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                              want.point, want.cluster, want.hit, want.last,
                              got.point, got.cluster, got.hit, got.last);
               end
            end
            rsp_gap = pick_gap();
         end
         if (rsp_gap > 0) begin
            rsp.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_pass_cap(logic [7:0] value);
      csr.valid <= 1'b1;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      pass_cap = value;
      csr.valid <= 1'b0;
   endtask

   task automatic add_load(load_kind_type k, logic [15:0] x, logic [15:0] y, logic last);
      load_request_type r;
      r.kind = k; r.x = x; r.y = y; r.last = last;
      pending_loads.push_back(r);
   endtask

   // one data set: npts points, nctr centers, mixed order; mostly clustered content unless spread
   task automatic add_data_set(int npts, int nctr, bit spread);
      int            total;
      int            p;
      int            c;
      logic [15:0]   bx;
      logic [15:0]   by;
      load_kind_type k;
      total = npts + nctr;
      p = 0; c = 0;
      bx = 16'($urandom); by = 16'($urandom);
      for (int i = 0; i < total; i++) begin
         if (c < nctr && (p >= npts || $urandom_range(0, 3) == 0)) begin
            k = LOAD_CENTER; c++;
         end else begin
            k = LOAD_POINT; p++;
         end
         if (spread || $urandom_range(0, 4) == 0)
            add_load(k, 16'($urandom), 16'($urandom), i == total - 1);
         else
            add_load(k, bx + 16'($urandom_range(0, 300)), by + 16'($urandom_range(0, 300)),
                     i == total - 1);
      end
   endtask

   task automatic run_phase();
      loading_done = 1;
      wait (pending_loads.size() == 0 && !req.valid && expected_labels.size() == 0);
      // a last request with no points gives no response; let the engine settle
      repeat (3000) @(posedge clock);
   endtask

   int sets;
   initial begin
      req.valid = 1'b0; req.req_type = 1'b0; req.coord_x = '0; req.coord_y = '0;
      req.last_item = 1'b0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.data = '0;
      pass_cap = 8'd32;
      n_points = 0; n_centers = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, ties, empty and full stores
      add_load(LOAD_POINT, 16'h0000, 16'h0000, 1'b0);
      add_load(LOAD_POINT, 16'hFFFF, 16'hFFFF, 1'b0);
      add_load(LOAD_CENTER, 16'hFFFF, 16'h0000, 1'b0);
      add_load(LOAD_CENTER, 16'h0000, 16'hFFFF, 1'b1);
      add_load(LOAD_POINT, 16'h5555, 16'hAAAA, 1'b0);
      add_load(LOAD_POINT, 16'hAAAA, 16'h5555, 1'b1);
      add_load(LOAD_CENTER, 16'h1234, 16'h4321, 1'b1);
      add_load(LOAD_POINT, 16'd10, 16'd10, 1'b0);
      add_load(LOAD_CENTER, 16'd10, 16'd10, 1'b0);
      add_load(LOAD_CENTER, 16'd10, 16'd10, 1'b0);
      add_load(LOAD_POINT, 16'd12, 16'd10, 1'b0);
      add_load(LOAD_CENTER, 16'd1000, 16'd1000, 1'b1);
      for (int i = 0; i < 11; i++)
         add_load(LOAD_CENTER, 16'(i * 97), 16'(i * 31), 1'b0);
      add_load(LOAD_POINT, 16'd50, 16'd60, 1'b1);
      run_phase();

      // store overflow: more points and centers than fit
      loading_done = 0;
      write_pass_cap(8'd0);
      for (int i = 0; i < 70; i++)
         add_load(LOAD_POINT, 16'($urandom), 16'($urandom), 1'b0);
      for (int i = 0; i < 10; i++)
         add_load(LOAD_CENTER, 16'($urandom), 16'($urandom), i == 9);
      run_phase();

      loading_done = 0;
      write_pass_cap(8'd255);
      add_data_set(64, 8, 1);
      run_phase();

      sets = 0;
      while (sets < 20) begin
         loading_done = 0;
         case ($urandom_range(0, 3))
            0: write_pass_cap(8'd1);
            1: write_pass_cap(8'd255);
            2: write_pass_cap(8'($urandom_range(2, 6)));
            default: write_pass_cap(8'($urandom));
         endcase
         for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 9) == 0)
               add_data_set($urandom_range(0, 3), $urandom_range(0, 2), 1);
            else
               add_data_set($urandom_range(2, 16), $urandom_range(1, 8),
                            $urandom_range(0, 1));
            sets++;
         end
         run_phase();
      end

      if (!failed && expected_labels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
